### hdl/word_graph_euler_path_check_assert.svh
// Assertion macros shared by the word graph Euler path checker.
// Depends on nothing; included by the modules that carry assertions.
`ifndef WORD_GRAPH_EULER_PATH_CHECK_ASSERT_SVH
`define WORD_GRAPH_EULER_PATH_CHECK_ASSERT_SVH
`ifndef SYNTHESIS
`define WGE_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define WGE_ASSERT_RST(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WGE_ASSERT(label, clk, rst_n, prop, msg)
`define WGE_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

### hdl/wgepc_pkg.sv
// Types, constants and helpers for the word graph Euler path checker.
// Depends on nothing; imported by every module of the block.
package wgepc_pkg;
	localparam int unsigned MaxNodesDef = 4096;
	localparam int unsigned AlphabetDef = 26;
	localparam int unsigned MaxWordsDef = 1024;
	localparam int unsigned MaxWordLenDef = 10;
	localparam int unsigned LetterBits = 5;
	localparam int unsigned WordBits = 50;
	localparam int unsigned CountBits = 11;

	localparam logic FUNC_ADD = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NODE_FULL = 2'd1,
		ST_WORD_FULL = 2'd2,
		ST_BAD = 2'd3
	} status_t;

	typedef struct packed {
		logic func;
		logic [WordBits-1:0] word_a;
		logic [3:0] len_a;
		logic [WordBits-1:0] word_b;
		logic [3:0] len_b;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic possible;
		logic [CountBits-1:0] odd_words;
		logic [CountBits-1:0] word_count;
		logic [CountBits-1:0] components;
	} out_item_t;

	// Classified command handed from the front part to the back part.
	typedef struct packed {
		logic query;
		logic bad;
		logic [WordBits-1:0] word_a;
		logic [3:0] len_a;
		logic [WordBits-1:0] word_b;
		logic [3:0] len_b;
	} cmd_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CLEAR,
		S_WSTART,
		S_WRD,
		S_WCHK,
		S_WNEXT,
		S_NEED,
		S_NEED2,
		S_TOUCHA,
		S_TOUCHB,
		S_TOUCHB2,
		S_FIND,
		S_FINDCHK,
		S_COMP,
		S_COMPCHK,
		S_LINK,
		S_EMIT
	} bstate_t;
endpackage

### hdl/wgepc_front.sv
// Front part: classifies each item, checks letters and lengths, queues commands.
// Depends on wgepc_pkg.
module wgepc_front
	import wgepc_pkg::*;
#(
	parameter int unsigned ALPHABET = AlphabetDef,
	parameter int unsigned MAX_WORD_LEN = MaxWordLenDef
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input in_item_t in_item,
	output logic cmd_valid,
	input logic cmd_take,
	output cmd_t cmd
);
	localparam int unsigned Depth = 2;

	cmd_t fifo_q [Depth];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t c;

	function automatic logic word_bad(logic [WordBits-1:0] w, logic [3:0] l);
		logic b;
		b = (l == 4'd0) || (32'(l) > MAX_WORD_LEN);
		for (int i = 0; i < int'(WordBits / LetterBits); i++) begin
			if (i < int'(l) && 32'(w[i*LetterBits +: LetterBits]) >= ALPHABET)
				b = 1'b1;
		end
		return b;
	endfunction

	always_comb begin
		c.query = (in_item.func == FUNC_QUERY);
		c.bad = !c.query && (word_bad(in_item.word_a, in_item.len_a) ||
			word_bad(in_item.word_b, in_item.len_b));
		c.word_a = in_item.word_a;
		c.len_a = in_item.len_a;
		c.word_b = in_item.word_b;
		c.len_b = in_item.len_b;
	end

	assign full = (cnt_q == 2'(Depth));
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full)
			fifo_q[wr_ptr_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full)
				wr_ptr_q <= !wr_ptr_q;
			if (cmd_take && cmd_valid)
				rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(cmd_take && cmd_valid);
		end
	end
endmodule

### hdl/wgepc_back.sv
// Back part: trie walks, degree parity, union-find and result queue.
// Depends on wgepc_pkg and the assertion macro header.
`include "word_graph_euler_path_check_assert.svh"
module wgepc_back
	import wgepc_pkg::*;
#(
	parameter int unsigned MAX_NODES = MaxNodesDef,
	parameter int unsigned ALPHABET = AlphabetDef,
	parameter int unsigned MAX_WORDS = MaxWordsDef
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_take,
	input cmd_t cmd,
	output logic empty,
	input logic pop,
	output out_item_t out_item
);
	localparam int unsigned NodeBits = $clog2(MAX_NODES);
	localparam int unsigned NcBits = $clog2(MAX_NODES + 1);
	localparam int unsigned Slots = MAX_NODES * ALPHABET;
	localparam int unsigned SlotBits = $clog2(Slots);
	localparam int unsigned IdBits = $clog2(MAX_WORDS + 1);

	// The child table is swept to zero once after reset. Node numbers only grow
	// until the next reset, so a freshly allocated row has never been written
	// and still reads as zero.
	logic [NodeBits-1:0] child_mem [Slots];
	logic [IdBits-1:0] wid_mem [MAX_NODES];
	logic par_mem [MAX_NODES];
	logic [IdBits-1:0] parent_mem [MAX_WORDS + 1];

	bstate_t state_q, state_d;
	logic [SlotBits-1:0] clr_q;
	logic [NcBits-1:0] nodes_q;
	logic [IdBits-1:0] next_id_q;
	logic [CountBits-1:0] odd_q, grp_q;

	logic wsel_q;
	logic [3:0] pos_q;
	logic [NodeBits-1:0] u_q, na_q, nb_q;
	logic [SlotBits-1:0] slot_q;
	logic [NodeBits-1:0] child_rd_q;
	logic [IdBits-1:0] wid_rd_q;
	logic par_rd_q;
	logic [IdBits-1:0] ia_q, ib_q, ida_q;
	logic para_q;
	logic [IdBits-1:0] r_q, x_q, ra_q, par_rd2_q;
	logic fsel_q;
	logic [1:0] stat_q;
	logic poss_q;

	out_item_t oq_q [2];
	logic ow_q, or_q;
	logic [1:0] ocnt_q;

	logic [3:0] cur_len;
	logic [LetterBits-1:0] cur_let;
	logic oq_push;
	logic alloc;
	logic word_full;
	logic touch_en;
	logic t_new, t_par;
	logic [IdBits-1:0] t_wid, t_id;
	logic [NodeBits-1:0] t_node;

	assign cur_len = wsel_q ? cmd.len_b : cmd.len_a;
	assign cur_let = wsel_q ? cmd.word_b[pos_q*LetterBits +: LetterBits]
		: cmd.word_a[pos_q*LetterBits +: LetterBits];

	assign alloc = (state_q == S_WCHK) && child_rd_q == '0 &&
		nodes_q < NcBits'(MAX_NODES);
	// Ids still needed by this edge, checked before either word is touched.
	assign word_full = (32'(next_id_q) - 32'd1 + 32'(ida_q == '0) +
		32'(wid_rd_q == '0 && nb_q != na_q)) > MAX_WORDS;
	assign touch_en = (state_q == S_TOUCHA && !word_full) || state_q == S_TOUCHB2;
	assign t_wid = (state_q == S_TOUCHA) ? ida_q : wid_rd_q;
	assign t_par = (state_q == S_TOUCHA) ? para_q : par_rd_q;
	assign t_node = (state_q == S_TOUCHA) ? na_q : nb_q;
	assign t_new = (t_wid == '0);
	assign t_id = t_new ? next_id_q : t_wid;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (clr_q == SlotBits'(Slots - 1)) state_d = S_IDLE;
			S_IDLE: begin
				if (cmd_valid && ocnt_q != 2'd2)
					state_d = (cmd.query || cmd.bad) ? S_EMIT : S_WSTART;
			end
			S_WSTART: state_d = S_WRD;
			S_WRD: state_d = (pos_q == cur_len) ? S_WNEXT : S_WCHK;
			S_WCHK: begin
				if (child_rd_q == '0 && nodes_q >= NcBits'(MAX_NODES))
					state_d = S_EMIT;
				else
					state_d = S_WRD;
			end
			S_WNEXT: state_d = wsel_q ? S_NEED : S_WRD;
			S_NEED: state_d = S_NEED2;
			S_NEED2: state_d = S_TOUCHA;
			S_TOUCHA: state_d = word_full ? S_EMIT : S_TOUCHB;
			S_TOUCHB: state_d = S_TOUCHB2;
			S_TOUCHB2: state_d = S_FIND;
			S_FIND: state_d = S_FINDCHK;
			S_FINDCHK: state_d = (par_rd2_q != r_q) ? S_FIND : S_COMP;
			S_COMP: state_d = S_COMPCHK;
			S_COMPCHK: begin
				if (x_q != r_q)
					state_d = S_COMP;
				else
					state_d = fsel_q ? S_LINK : S_FIND;
			end
			S_LINK: state_d = S_EMIT;
			S_EMIT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd_take = (state_q == S_EMIT);
		oq_push = (state_q == S_EMIT);
	end

	// Memories: synchronous reads and writes.
	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR)
			child_mem[clr_q] <= '0;
		else if (alloc)
			child_mem[slot_q] <= NodeBits'(nodes_q);
		if (state_q == S_WRD)
			child_rd_q <= child_mem[SlotBits'(32'(u_q) * ALPHABET + 32'(cur_let))];
	end

	// The second word is read again after the first is touched, so that a
	// self loop sees the parity left by the first touch.
	always_ff @(posedge clk) begin
		if (alloc) begin
			wid_mem[NodeBits'(nodes_q)] <= '0;
			par_mem[NodeBits'(nodes_q)] <= 1'b0;
		end else if (touch_en) begin
			wid_mem[t_node] <= t_id;
			par_mem[t_node] <= t_new ? 1'b1 : !t_par;
		end
		wid_rd_q <= wid_mem[(state_q == S_NEED) ? na_q : nb_q];
		par_rd_q <= par_mem[(state_q == S_NEED) ? na_q : nb_q];
	end

	always_ff @(posedge clk) begin
		if (touch_en && t_new)
			parent_mem[next_id_q] <= next_id_q;
		else if (state_q == S_COMPCHK && x_q != r_q)
			parent_mem[x_q] <= r_q;
		else if (state_q == S_LINK && ra_q != r_q)
			parent_mem[ra_q] <= r_q;
		par_rd2_q <= parent_mem[(state_q == S_FIND) ? r_q : x_q];
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				wsel_q <= 1'b0;
				stat_q <= cmd.query ? ST_OK : (cmd.bad ? ST_BAD : ST_OK);
				poss_q <= cmd.query && (odd_q == '0 || odd_q == CountBits'(2)) &&
					grp_q <= CountBits'(1);
			end
			S_WSTART: begin
				pos_q <= 4'd0;
				u_q <= '0;
			end
			S_WRD: slot_q <= SlotBits'(32'(u_q) * ALPHABET + 32'(cur_let));
			S_WCHK: begin
				if (child_rd_q == '0 && nodes_q >= NcBits'(MAX_NODES)) begin
					stat_q <= ST_NODE_FULL;
				end else begin
					u_q <= (child_rd_q == '0) ? NodeBits'(nodes_q) : child_rd_q;
					pos_q <= pos_q + 4'd1;
				end
			end
			S_WNEXT: begin
				if (!wsel_q) begin
					na_q <= u_q;
					wsel_q <= 1'b1;
					pos_q <= 4'd0;
					u_q <= '0;
				end else begin
					nb_q <= u_q;
				end
			end
			S_NEED2: begin
				ida_q <= wid_rd_q;
				para_q <= par_rd_q;
			end
			S_TOUCHA: begin
				if (word_full)
					stat_q <= ST_WORD_FULL;
				else
					ia_q <= t_id;
			end
			S_TOUCHB2: begin
				ib_q <= t_id;
				r_q <= ia_q;
				x_q <= ia_q;
				fsel_q <= 1'b0;
			end
			S_FINDCHK: begin
				if (par_rd2_q != r_q)
					r_q <= par_rd2_q;
			end
			S_COMPCHK: begin
				if (x_q != r_q) begin
					x_q <= par_rd2_q;
				end else if (!fsel_q) begin
					ra_q <= r_q;
					r_q <= ib_q;
					x_q <= ib_q;
					fsel_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			nodes_q <= NcBits'(1);
			next_id_q <= IdBits'(1);
			odd_q <= '0;
			grp_q <= '0;
			ow_q <= 1'b0;
			or_q <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR)
				clr_q <= clr_q + 1'b1;
			if (alloc)
				nodes_q <= nodes_q + 1'b1;
			if (touch_en) begin
				if (t_new) begin
					next_id_q <= next_id_q + 1'b1;
					odd_q <= odd_q + 1'b1;
					grp_q <= grp_q + 1'b1;
				end else if (t_par) begin
					odd_q <= odd_q - 1'b1;
				end else begin
					odd_q <= odd_q + 1'b1;
				end
			end else if (state_q == S_LINK && ra_q != r_q) begin
				grp_q <= grp_q - 1'b1;
			end
			if (oq_push)
				ow_q <= !ow_q;
			if (pop && !empty)
				or_q <= !or_q;
			ocnt_q <= ocnt_q + 2'(oq_push) - 2'(pop && !empty);
		end
	end

	always_ff @(posedge clk) begin
		if (oq_push) begin
			oq_q[ow_q].status <= stat_q;
			oq_q[ow_q].possible <= poss_q;
			oq_q[ow_q].odd_words <= odd_q;
			oq_q[ow_q].word_count <= CountBits'(next_id_q - 1'b1);
			oq_q[ow_q].components <= grp_q;
		end
	end

	assign empty = (ocnt_q == 2'd0);
	assign out_item = oq_q[or_q];

	`WGE_ASSERT(a_oq_bound, clk, arst_n, ocnt_q <= 2'd2, "result queue overflow")
	`WGE_ASSERT(a_take_emit, clk, arst_n, cmd_take |-> cmd_valid, "command taken from empty queue")
	`WGE_ASSERT(a_nodes_bound, clk, arst_n, 32'(nodes_q) <= MAX_NODES, "node count beyond pool")
endmodule

### hdl/word_graph_euler_path_check.sv
// Word graph Euler path checker. Each input beat either adds an edge between two
// lower-case words of one to ten letters, five bits a letter, or asks whether the
// edges seen so far admit an Euler path. Every input beat gives exactly one result
// beat, in order, with a status, the verdict and the running counts of odd-degree
// words, distinct words and components. After reset the block clears all
// MAX_NODES * ALPHABET entries (106496 with the defaults) of its trie before
// the engine takes its first command; up to two commands queue meanwhile. In the
// engine a query or an item with a bad letter or length goes straight to its
// result; an add walks both words through the trie, touches both words and follows
// the union-find links from either word before it links their roots. The front
// queues each item and takes the next item while the engine works, until its queue is full.
module word_graph_euler_path_check
	import wgepc_pkg::*;
#(
	parameter int unsigned MAX_NODES = MaxNodesDef,
	parameter int unsigned ALPHABET = AlphabetDef,
	parameter int unsigned MAX_WORDS = MaxWordsDef,
	parameter int unsigned MAX_WORD_LEN = MaxWordLenDef
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input in_item_t in_item,
	output logic empty,
	input logic pop,
	output out_item_t out_item
);
	logic cmd_valid, cmd_take;
	cmd_t cmd;

	wgepc_front #(.ALPHABET(ALPHABET), .MAX_WORD_LEN(MAX_WORD_LEN)) u_front (
		.clk, .arst_n, .push, .full, .in_item, .cmd_valid, .cmd_take, .cmd
	);

	wgepc_back #(.MAX_NODES(MAX_NODES), .ALPHABET(ALPHABET), .MAX_WORDS(MAX_WORDS)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd_take, .cmd, .empty, .pop, .out_item
	);
endmodule

### verif/word_graph_euler_path_check_monitor.sv
// Checker for the word graph Euler path checker: watches both queue ports,
// predicts each result from its own trie and union-find copy, and compares. Depends on wgepc_pkg.
module word_graph_euler_path_check_monitor
	import wgepc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input in_item_t in_item,
	input logic empty,
	input logic pop,
	input out_item_t out_item,
	output int errors,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NODES = MaxNodesDef;
	localparam int unsigned LETTERS = AlphabetDef;
	localparam int unsigned WORDS = MaxWordsDef;
	localparam int unsigned LEN_MAX = MaxWordLenDef;

	int unsigned trie_child[NODES*LETTERS];
	int unsigned trie_word_id[NODES];
	bit trie_odd[NODES];
	int unsigned word_parent[WORDS+1];
	int unsigned trie_nodes;
	int unsigned next_id;
	int unsigned odd_count;
	int unsigned group_count;
	out_item_t verdict_q[$];

	initial begin
		foreach (trie_child[i]) trie_child[i] = 0;
		foreach (trie_word_id[i]) trie_word_id[i] = 0;
		foreach (trie_odd[i]) trie_odd[i] = 0;
		foreach (word_parent[i]) word_parent[i] = 0;
		trie_nodes = 1;
		next_id = 1;
		odd_count = 0;
		group_count = 0;
	end

	function automatic bit word_valid(logic [WordBits-1:0] w, logic [3:0] len);
		if (len < 1 || len > LEN_MAX)
			return 0;
		for (int i = 0; i < len; i++)
			if (w[i*LetterBits +: LetterBits] >= LETTERS)
				return 0;
		return 1;
	endfunction

	// Returns 1 when a new node was needed but the pool was exhausted.
	function automatic bit trie_walk(logic [WordBits-1:0] w, logic [3:0] len,
			output int unsigned last);
		int unsigned u;
		int unsigned slot;
		u = 0;
		last = 0;
		for (int i = 0; i < len; i++) begin
			slot = u * LETTERS + w[i*LetterBits +: LetterBits];
			if (trie_child[slot] == 0) begin
				if (trie_nodes >= NODES)
					return 1;
				for (int c = 0; c < LETTERS; c++)
					trie_child[trie_nodes*LETTERS + c] = 0;
				trie_word_id[trie_nodes] = 0;
				trie_odd[trie_nodes] = 0;
				trie_child[slot] = trie_nodes;
				trie_nodes++;
			end
			u = trie_child[slot];
		end
		last = u;
		return 0;
	endfunction

	function automatic int unsigned visit_word(int unsigned node);
		int unsigned id;
		id = trie_word_id[node];
		if (id == 0) begin
			id = next_id++;
			trie_word_id[node] = id;
			trie_odd[node] = 1;
			odd_count++;
			word_parent[id] = id;
			group_count++;
		end else begin
			trie_odd[node] = !trie_odd[node];
			if (trie_odd[node])
				odd_count++;
			else
				odd_count--;
		end
		return id;
	endfunction

	function automatic int unsigned find_group(int unsigned x);
		int unsigned r;
		int unsigned nx;
		r = x;
		while (word_parent[r] != r)
			r = word_parent[r];
		while (x != r) begin
			nx = word_parent[x];
			word_parent[x] = r;
			x = nx;
		end
		return r;
	endfunction

	function automatic out_item_t predict_verdict(in_item_t it);
		out_item_t res;
		int unsigned na, nb, ia, ib, ra, rb, need;
		status_t st;
		st = ST_OK;
		res = '0;
		if (it.func == FUNC_QUERY) begin
			res.possible = (odd_count == 0 || odd_count == 2) && group_count <= 1;
		end else if (!word_valid(it.word_a, it.len_a) || !word_valid(it.word_b, it.len_b)) begin
			st = ST_BAD;
		end else if (trie_walk(it.word_a, it.len_a, na) || trie_walk(it.word_b, it.len_b, nb)) begin
			st = ST_NODE_FULL;
		end else begin
			need = (trie_word_id[na] == 0) + (trie_word_id[nb] == 0 && nb != na);
			if (next_id - 1 + need > WORDS) begin
				st = ST_WORD_FULL;
			end else begin
				ia = visit_word(na);
				ib = visit_word(nb);
				ra = find_group(ia);
				rb = find_group(ib);
				if (ra != rb) begin
					word_parent[ra] = rb;
					group_count--;
				end
			end
		end
		res.status = st;
		res.odd_words = CountBits'(odd_count);
		res.word_count = CountBits'(next_id - 1);
		res.components = CountBits'(group_count);
		return res;
	endfunction

	task automatic report(string field, int got, int want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (push && !full)
				verdict_q.insert(verdict_q.size(), predict_verdict(in_item));
			if (pop && !empty) begin
				if (verdict_q.size() == 0) begin
					report("unexpected result beat", 1, 0);
				end else begin
					want = verdict_q.pop_front();
					if (out_item.status !== want.status)
						report("status", out_item.status, want.status);
					if (out_item.possible !== want.possible)
						report("possible", out_item.possible, want.possible);
					if (out_item.odd_words !== want.odd_words)
						report("odd_words", out_item.odd_words, want.odd_words);
					if (out_item.word_count !== want.word_count)
						report("word_count", out_item.word_count, want.word_count);
					if (out_item.components !== want.components)
						report("components", out_item.components, want.components);
				end
			end
			pending = verdict_q.size();
		end
	end
endmodule

### verif/word_graph_euler_path_check_tb.sv
// Stimulus and verdict for the word graph Euler path checker.
// Depends on wgepc_pkg, the block and word_graph_euler_path_check_monitor.
module word_graph_euler_path_check_tb;
	import wgepc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	in_item_t in_item;
	logic empty;
	logic pop;
	out_item_t out_item;
	int errors;
	int pending;

	bit calm;
	bit hold_go;
	logic [WordBits-1:0] vocab_word[24];
	logic [3:0] vocab_len[24];

	word_graph_euler_path_check uut (.*);
	word_graph_euler_path_check_monitor checker_i (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("[word_graph_euler_path_check] ERROR");
		$finish;
	end

	// Result side: random stall bursts, one long hold on request, none at the end.
	initial begin
		int gap;
		pop = 0;
		gap = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_go) begin
				pop <= 0;
				for (int i = 1; i < 400; i++) @(posedge clk);
				hold_go = 0;
			end else if (calm) begin
				pop <= 1;
			end else if (gap > 0) begin
				pop <= 0;
				gap--;
			end else if ($urandom_range(7) == 0) begin
				pop <= 0;
				gap = $urandom_range(14);
			end else begin
				pop <= 1;
			end
		end
	end

	function automatic logic [WordBits-1:0] letters_of(int unsigned k, int n);
		logic [WordBits-1:0] w;
		w = '0;
		for (int i = 0; i < n; i++) begin
			w[i*LetterBits +: LetterBits] = LetterBits'(k % 26);
			k = k / 26;
		end
		return w;
	endfunction

	function automatic logic [WordBits-1:0] random_letters(int top);
		logic [WordBits-1:0] w;
		for (int i = 0; i < 10; i++)
			w[i*LetterBits +: LetterBits] = LetterBits'($urandom_range(top));
		return w;
	endfunction

	task automatic send(logic f, logic [WordBits-1:0] wa, logic [3:0] la,
			logic [WordBits-1:0] wb, logic [3:0] lb);
		in_item_t it;
		it = '{func: f, word_a: wa, len_a: la, word_b: wb, len_b: lb};
		if (!calm && $urandom_range(5) == 0) begin
			push <= 0;
			repeat ($urandom_range(15, 1)) @(posedge clk);
		end
		push <= 1;
		in_item <= it;
		do @(posedge clk); while (full);
	endtask

	task automatic send_query();
		send(FUNC_QUERY, WordBits'({$urandom, $urandom}), 4'($urandom),
			WordBits'({$urandom, $urandom}), 4'($urandom));
	endtask

	// Mostly pairs from a small vocabulary so that the graph joins up; some junk.
	task automatic send_vocab_edge();
		int a, b;
		a = $urandom_range(23);
		b = $urandom_range(23);
		case ($urandom_range(19))
			0, 1: send_query();
			2: send(FUNC_ADD, WordBits'({$urandom, $urandom}), 4'($urandom),
				WordBits'({$urandom, $urandom}), 4'($urandom));
			default: send(FUNC_ADD, vocab_word[a], vocab_len[a], vocab_word[b], vocab_len[b]);
		endcase
	endtask

	initial begin
		logic [WordBits-1:0] zz;
		int unsigned fresh;
		arst_n = 0;
		push = 0;
		in_item = '0;
		calm = 0;
		hold_go = 0;
		for (int i = 0; i < 24; i++) begin
			vocab_len[i] = 4'($urandom_range(4, 1));
			vocab_word[i] = random_letters(5) & ~({WordBits{1'b1}} << (vocab_len[i] * LetterBits));
		end
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		zz = letters_of(0, 10) | {10{5'd25}};
		// Directed: empty graph, self loop, plain edge, bad lengths and letters, extremes.
		send_query();
		send(FUNC_ADD, letters_of(0, 1), 1, letters_of(0, 1), 1);
		send_query();
		send(FUNC_ADD, letters_of(0, 1), 1, letters_of(1, 1), 1);
		send_query();
		send(FUNC_ADD, zz, 10, letters_of(0, 1), 1);
		send(FUNC_ADD, zz, 10, zz, 10);
		send(FUNC_ADD, {WordBits{1'b1}}, 10, zz, 10);
		send(FUNC_ADD, zz, 10, {WordBits{1'b1}}, 1);
		send(FUNC_ADD, {{45{1'b1}}, 5'd26}, 1, zz, 10);
		send(FUNC_ADD, {{45{1'b1}}, 5'd2}, 1, letters_of(3, 1), 1);
		send(FUNC_ADD, zz, 0, zz, 10);
		send(FUNC_ADD, zz, 10, zz, 11);
		send(FUNC_ADD, zz, 15, zz, 15);
		send(FUNC_ADD, letters_of(7, 1), 1, letters_of(8, 1), 1);
		send_query();
		send(FUNC_QUERY, '0, 0, '0, 0);

		for (int n = 0; n < 400; n++) begin
			if (n == 200)
				hold_go = 1;
			send_vocab_edge();
		end

		// Many distinct words so that the id pool runs out.
		fresh = 0;
		for (int n = 0; n < 540; n++) begin
			if ($urandom_range(9) == 0) begin
				send_query();
			end else begin
				send(FUNC_ADD, letters_of(fresh, 3) | (5'd24 << 15), 4,
					letters_of(fresh + 1, 3) | (5'd24 << 15), 4);
				fresh += 2;
			end
		end

		// Long random words until the node pool runs out too; no idling at the end.
		for (int n = 0; n < 220; n++) begin
			if (n == 120)
				calm = 1;
			if ($urandom_range(9) == 0)
				send_query();
			else if ($urandom_range(9) == 0)
				send_vocab_edge();
			else
				send(FUNC_ADD, random_letters(25), 10, random_letters(25),
					4'($urandom_range(10, 1)));
		end
		push <= 0;
		@(posedge clk);

		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("[word_graph_euler_path_check] OK");
		else
			$display("[word_graph_euler_path_check] ERROR");
		$finish;
	end
endmodule
